>>> rtl/edf_preemptive_scheduler_top_defines.svh
// Assertion macros for the EDF scheduler checker
`ifndef EDF_PREEMPTIVE_SCHEDULER_TOP_DEFINES_SVH
`define EDF_PREEMPTIVE_SCHEDULER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define EDFS_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define EDFS_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/edfs_pkg.sv
// Types, constants and action codes for the EDF scheduler
package edfs_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int TIME_W        = 20;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [3:0] DEADLINE_FACTOR_RST = 4'd2;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	typedef struct packed {
		logic [7:0]        id;
		logic [15:0]       arrival;
		logic [15:0]       burst;
		logic [15:0]       remaining;
		logic [TIME_W-1:0] deadline;
	} entry_t;

	typedef struct packed {
		logic init;
		logic cmp_v;
		logic elig;
	} pick_ctl_t;

endpackage

>>> rtl/edf_preemptive_scheduler_top.sv
// Preemptive EDF scheduler: task table memory, slot scan and tick update
// Load and clear transactions give no result.
// A tick reads the table one slot at a time through the single read port in SCAN,
// does the last compare in DRAIN and writes back and registers the result in UPD.
// Input stalls until a tick is back in idle; results may wait in the output register.
// Reset: time 0, deadline factor 2, all slots empty; table contents are not cleared.
module edf_preemptive_scheduler_top import edfs_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [3:0]  task_slot,
	input  logic [7:0]  task_id,
	input  logic [15:0] arrival,
	input  logic [15:0] burst,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [19:0] tick_time,
	output logic        busy_res,
	output logic [3:0]  run_slot,
	output logic [7:0]  run_id,
	output logic        finished,
	output logic [19:0] turnaround,
	output logic [19:0] waiting,
	output logic        all_done
);

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_UPD   = 2'd3;

	logic [1:0]           state_q;
	logic [TIME_W-1:0]    time_q;
	logic [3:0]           factor_q;
	logic [MAX_TASKS-1:0] work_q;
	logic [IDX_W-1:0]     rd_addr_q;
	logic                 cmp_v_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	entry_t               rd_data_s1;
	entry_t               table_q [MAX_TASKS];

	logic                 out_valid_q;
	logic [19:0]          tick_time_q;
	logic                 busy_q;
	logic [3:0]           run_slot_q;
	logic [7:0]           run_id_q;
	logic                 fin_q;
	logic [19:0]          tat_q;
	logic [19:0]          wt_q;
	logic                 done_q;

	logic                 in_acc;
	logic                 load_go;
	logic                 upd_go;
	logic [IDX_W-1:0]     load_idx;
	entry_t               load_entry;
	logic [19:0]          prod;

	pick_ctl_t            pctl;
	logic                 found;
	logic [IDX_W-1:0]     best_slot;
	entry_t               best;

	logic [TIME_W-1:0]    new_time;
	logic [15:0]          rem_nx;
	logic                 fin_nx;
	logic [TIME_W-1:0]    tat_nx;
	logic [TIME_W-1:0]    wt_nx;
	logic [MAX_TASKS-1:0] work_upd;
	entry_t               upd_entry;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign load_go  = in_acc && (action == ACT_LOAD) && (32'(task_slot) < MAX_TASKS);
	assign upd_go   = (state_q == ST_UPD) && !(out_valid_q && out_stall);
	assign load_idx = IDX_W'(task_slot);

	assign prod = 20'(factor_q) * 20'(burst);

	always_comb begin
		load_entry.id        = task_id;
		load_entry.arrival   = arrival;
		load_entry.burst     = burst;
		load_entry.remaining = burst;
		load_entry.deadline  = 20'(arrival) + prod;
	end

	// tick update
	always_comb begin
		new_time = (time_q == TIME_MAX) ? time_q : time_q + 20'd1;
		rem_nx   = best.remaining - 16'd1;
		fin_nx   = found && (rem_nx == 16'd0);
		tat_nx   = new_time - 20'(best.arrival);
		wt_nx    = (tat_nx >= 20'(best.burst)) ? tat_nx - 20'(best.burst) : '0;
		work_upd = work_q;
		if (fin_nx)
			work_upd[best_slot] = 1'b0;
		upd_entry           = best;
		upd_entry.remaining = rem_nx;
	end

	always_comb begin
		pctl.init  = in_acc && (action == ACT_TICK);
		pctl.cmp_v = cmp_v_s1;
		pctl.elig  = work_q[cmp_idx_s1] && ({4'd0, rd_data_s1.arrival} <= time_q);
	end

	edfs_pick #(
		.MAX_TASKS(MAX_TASKS)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pctl),
		.cand_idx (cmp_idx_s1),
		.cand     (rd_data_s1),
		.found    (found),
		.best_slot(best_slot),
		.best     (best)
	);

	// task table
	always_ff @(posedge clk) begin
		if (load_go)
			table_q[load_idx] <= load_entry;
		else if (upd_go && found)
			table_q[best_slot] <= upd_entry;
		rd_data_s1 <= table_q[rd_addr_q];
		cmp_idx_s1 <= rd_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			time_q    <= '0;
			factor_q  <= DEADLINE_FACTOR_RST;
			work_q    <= '0;
			rd_addr_q <= '0;
			cmp_v_s1  <= 1'b0;
		end else begin
			cmp_v_s1 <= (state_q == ST_SCAN);
			if (cfg_we)
				factor_q <= cfg_wdata;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (action)
							ACT_LOAD: begin
								if (load_go)
									work_q[load_idx] <= (burst != 16'd0);
							end
							ACT_TICK: begin
								rd_addr_q <= '0;
								state_q   <= ST_SCAN;
							end
							ACT_CLEAR: begin
								work_q <= '0;
								time_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_addr_q == LAST_IDX)
						state_q <= ST_DRAIN;
					else
						rd_addr_q <= rd_addr_q + IDX_W'(1);
				end
				ST_DRAIN: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) begin
						time_q  <= new_time;
						work_q  <= work_upd;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (upd_go)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			tick_time_q <= time_q;
			busy_q      <= found;
			run_slot_q  <= found ? 4'(best_slot) : 4'd0;
			run_id_q    <= found ? best.id : 8'd0;
			fin_q       <= fin_nx;
			tat_q       <= fin_nx ? tat_nx : 20'd0;
			wt_q        <= fin_nx ? wt_nx : 20'd0;
			done_q      <= ~|work_upd;
		end
	end

	assign out_valid  = out_valid_q;
	assign tick_time  = tick_time_q;
	assign busy_res   = busy_q;
	assign run_slot   = run_slot_q;
	assign run_id     = run_id_q;
	assign finished   = fin_q;
	assign turnaround = tat_q;
	assign waiting    = wt_q;
	assign all_done   = done_q;

endmodule

>>> rtl/edfs_pick.sv
// Running earliest-deadline selection over the slots streamed from the task table
module edfs_pick import edfs_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pick_ctl_t                      ctl,
	input  logic [$clog2(MAX_TASKS)-1:0]   cand_idx,
	input  entry_t                         cand,
	output logic                           found,
	output logic [$clog2(MAX_TASKS)-1:0]   best_slot,
	output entry_t                         best
);

	localparam int IDX_W = $clog2(MAX_TASKS);

	logic             found_q;
	logic [IDX_W-1:0] slot_q;
	entry_t           best_q;
	logic             beats;

	always_comb begin
		if (cand.deadline != best_q.deadline)
			beats = cand.deadline < best_q.deadline;
		else if (cand.arrival != best_q.arrival)
			beats = cand.arrival < best_q.arrival;
		else
			beats = cand.id < best_q.id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.init) begin
			found_q <= 1'b0;
		end else if (ctl.cmp_v && ctl.elig) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp_v && ctl.elig && (!found_q || beats)) begin
			slot_q <= cand_idx;
			best_q <= cand;
		end
	end

	assign found     = found_q;
	assign best_slot = slot_q;
	assign best      = best_q;

endmodule

>>> rtl/edfs_checker.sv
// Port-level checker for the EDF scheduler, bound to the top level
`include "edf_preemptive_scheduler_top_defines.svh"

module edfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        busy_res,
	input logic [3:0]  run_slot,
	input logic [7:0]  run_id,
	input logic        finished,
	input logic [19:0] turnaround,
	input logic [19:0] waiting,
	input logic        all_done
);

	`EDFS_AST_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`EDFS_AST_IMP(a_idle_clean, out_valid && !busy_res, !finished && run_slot == 4'd0 && run_id == 8'd0, "idle tick reports a task")
	`EDFS_AST_IMP(a_times_zero, out_valid && !finished, turnaround == 20'd0 && waiting == 20'd0, "times set without completion")
	`EDFS_AST_IMP(a_wait_le_tat, out_valid && finished, waiting <= turnaround, "waiting exceeds turnaround")
	`EDFS_AST_IMP(a_last_done, out_valid && busy_res && all_done, finished, "table empty but running task unfinished")

endmodule

bind edf_preemptive_scheduler_top edfs_checker u_edfs_checker (.*);
